[design/cubemap_to_equirect_sample_coords_top_defines.svh]
// Assertion macros for the sample coordinate generator.
`ifndef CUBEMAP_TO_EQUIRECT_SAMPLE_COORDS_TOP_DEFINES_SVH
`define CUBEMAP_TO_EQUIRECT_SAMPLE_COORDS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define CMEP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CMEP_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CMEP_CHECK(lbl, prop, msg)
`define CMEP_IMPLY(lbl, ante, cons, msg)
`endif

`endif

[design/cmep_pkg.sv]
package cmep_pkg;

  localparam int ANGLE_BITS_DEF = 20;
  localparam int DIR_GUARD      = 16;
  localparam int DW             = 37;
  localparam int DIR_W          = 15;
  localparam int GAIN_SHIFT     = 30 - DIR_GUARD;
  localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195369;
  localparam int COORD_LIMIT    = 16383;
  localparam logic [14:0] WIDTH_RESET  = 15'd4096;
  localparam logic [14:0] HEIGHT_RESET = 15'd2048;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef enum logic {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [31:0] TURN_ATAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  function automatic logic [32:0] step_angle(input int i, input int ab);
    logic [32:0] t;
    int sh;
    t  = {1'b0, TURN_ATAN[i[4:0]]};
    sh = 32 - ab;
    if (sh == 0) begin
      return t;
    end
    return (t + (33'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

[design/cmep_cell.sv]
module cmep_cell #(
  parameter int STAGE      = 0,
  parameter int ANGLE_BITS = cmep_pkg::ANGLE_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic                          zero_i,
  input  logic signed [cmep_pkg::DW-1:0] x_i,
  input  logic signed [cmep_pkg::DW-1:0] y_i,
  input  logic signed [ANGLE_BITS+1:0]  z_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          vld_o,
  output logic                          zero_o,
  output logic signed [cmep_pkg::DW-1:0] x_o,
  output logic signed [cmep_pkg::DW-1:0] y_o,
  output logic signed [ANGLE_BITS+1:0]  z_o,
  output logic [SIDE_W-1:0]             side_o
);
  import cmep_pkg::*;

  localparam int ZW = ANGLE_BITS + 2;
  localparam logic signed [ZW-1:0] STEP = ZW'(step_angle(STAGE, ANGLE_BITS));

  logic                 vld_r, zero_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SIDE_W-1:0]    side_r;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + STEP;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= zero_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign zero_o = zero_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

[design/cmep_fp.sv]
module cmep_fp #(
  parameter int ANGLE_BITS = cmep_pkg::ANGLE_BITS_DEF
) (
  input  logic signed [ANGLE_BITS+19:0] held,
  input  logic [14:0]                   size,
  output logic [13:0]                   lo,
  output logic [13:0]                   hi,
  output logic [15:0]                   frac
);
  import cmep_pkg::*;

  localparam int HW = ANGLE_BITS + 20;
  localparam int SR = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SL = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  logic [14:0]          lim15;
  logic [13:0]          lim;
  logic signed [HW-1:0] lo_raw;
  logic signed [HW:0]   lo_sh, diff;
  logic signed [HW+16:0] q;

  always_comb begin
    lim15 = (size == 15'd0) ? 15'd0 : size - 15'd1;
    lim   = (lim15 > 15'(COORD_LIMIT)) ? 14'(COORD_LIMIT) : lim15[13:0];
    lo_raw = held >>> ANGLE_BITS;
    if (lo_raw < 0) begin
      lo = 14'd0;
    end else if (lo_raw > $signed({{(HW-14){1'b0}}, lim})) begin
      lo = lim;
    end else begin
      lo = lo_raw[13:0];
    end
    hi = ({1'b0, lo} + 15'd1 > {1'b0, lim}) ? lim : lo + 14'd1;
    lo_sh = $signed({{(HW+1-14){1'b0}}, lo}) <<< ANGLE_BITS;
    diff  = (HW+1)'(held) - lo_sh;
    q     = ((HW+17)'(diff) >>> SR) <<< SL;
    if (q < 0) begin
      frac = 16'd0;
    end else if (q > 65535) begin
      frac = 16'hFFFF;
    end else begin
      frac = q[15:0];
    end
  end

endmodule

[design/cubemap_to_equirect_sample_coords_top.sv]
// Cubemap to equirectangular sample coordinate generator. Takes one cubemap
// pixel (face, x, y) per cycle unless the output stalls, and returns the
// bilinear footprint in the equirectangular source: clamped left/right
// columns, top/bottom rows and Q0.16 blend fractions. Fully pipelined
// through two chains of ANGLE_BITS CORDIC cells (longitude, then latitude)
// plus direction, pre-rotation, scaling and footprint stages, one item per
// cycle sustained; a stalled output freezes the whole pipeline.
// Write source_width/source_height only while no transaction is in flight.
module cubemap_to_equirect_sample_coords_top #(
  parameter int ANGLE_BITS = cmep_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_face,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_col_left,
  output logic [13:0] out_col_right,
  output logic [13:0] out_row_top,
  output logic [13:0] out_row_bottom,
  output logic [15:0] out_frac_s,
  output logic [15:0] out_frac_t,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  import cmep_pkg::*;
  `include "cubemap_to_equirect_sample_coords_top_defines.svh"

  localparam int ZW = ANGLE_BITS + 2;
  localparam int HW = ANGLE_BITS + 20;
  localparam int PW = DIR_W + 32;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [ZW:0]   HALF    = (ZW+1)'(1) <<< (ANGLE_BITS - 1);

  logic [14:0] width_r, height_r;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SOURCE_WIDTH:  width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // direction vector
  logic                    s0_vld_r;
  logic signed [DIR_W-1:0] s0_dx_r, s0_dy_r, s0_dz_r;
  logic signed [DIR_W-1:0] dx_nxt, dy_nxt, dz_nxt, n_s, a_s, b_s;

  always_comb begin
    n_s = $signed({2'b00, width_r[14:2]});
    a_s = $signed({2'b00, in_pixel_x, 1'b1}) - n_s;
    b_s = $signed({2'b00, in_pixel_y, 1'b1}) - n_s;
    dx_nxt = '0;
    dy_nxt = '0;
    dz_nxt = '0;
    unique case (face_t'(in_face))
      FACE_PX: begin dx_nxt = n_s;  dy_nxt = -b_s; dz_nxt = -a_s; end
      FACE_NX: begin dx_nxt = -n_s; dy_nxt = -b_s; dz_nxt = a_s;  end
      FACE_PY: begin dx_nxt = a_s;  dy_nxt = n_s;  dz_nxt = b_s;  end
      FACE_NY: begin dx_nxt = a_s;  dy_nxt = -n_s; dz_nxt = -b_s; end
      FACE_PZ: begin dx_nxt = a_s;  dy_nxt = -b_s; dz_nxt = n_s;  end
      FACE_NZ: begin dx_nxt = -a_s; dy_nxt = -b_s; dz_nxt = -n_s; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx_r <= dx_nxt;
      s0_dy_r <= dy_nxt;
      s0_dz_r <= dz_nxt;
    end
  end

  // longitude chain
  logic                 c1_vld [ANGLE_BITS+1];
  logic                 c1_zero[ANGLE_BITS+1];
  logic signed [DW-1:0] c1_x   [ANGLE_BITS+1];
  logic signed [DW-1:0] c1_y   [ANGLE_BITS+1];
  logic signed [ZW-1:0] c1_z   [ANGLE_BITS+1];
  logic [DW-1:0]        c1_s   [ANGLE_BITS+1];

  logic                 p1_vld_r, p1_zero_r;
  logic signed [DW-1:0] p1_x_r, p1_y_r, p1_ys_r, p1_x_nxt, p1_y_nxt, raw_x1, raw_y1;
  logic signed [ZW-1:0] p1_z_r, p1_z_nxt;
  logic signed [PW-1:0] prod;

  always_comb begin
    raw_x1 = DW'(s0_dx_r) <<< DIR_GUARD;
    raw_y1 = DW'(s0_dz_r) <<< DIR_GUARD;
    p1_x_nxt = raw_x1;
    p1_y_nxt = raw_y1;
    p1_z_nxt = '0;
    if (raw_x1 < 0) begin
      if (raw_y1 >= 0) begin
        p1_x_nxt = raw_y1;
        p1_y_nxt = -raw_x1;
        p1_z_nxt = QUARTER;
      end else begin
        p1_x_nxt = -raw_y1;
        p1_y_nxt = raw_x1;
        p1_z_nxt = -QUARTER;
      end
    end
    prod = PW'(s0_dy_r) * PW'(GAIN_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_zero_r <= (s0_dx_r == '0) && (s0_dz_r == '0);
      p1_x_r    <= p1_x_nxt;
      p1_y_r    <= p1_y_nxt;
      p1_z_r    <= p1_z_nxt;
      p1_ys_r   <= DW'(prod >>> GAIN_SHIFT);
    end
  end

  assign c1_vld[0]  = p1_vld_r;
  assign c1_zero[0] = p1_zero_r;
  assign c1_x[0]    = p1_x_r;
  assign c1_y[0]    = p1_y_r;
  assign c1_z[0]    = p1_z_r;
  assign c1_s[0]    = p1_ys_r;

  for (genvar g = 0; g < ANGLE_BITS; g++) begin : g_lon
    cmep_cell #(.STAGE(g), .ANGLE_BITS(ANGLE_BITS), .SIDE_W(DW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(c1_vld[g]), .zero_i(c1_zero[g]), .x_i(c1_x[g]), .y_i(c1_y[g]),
      .z_i(c1_z[g]), .side_i(c1_s[g]),
      .vld_o(c1_vld[g+1]), .zero_o(c1_zero[g+1]), .x_o(c1_x[g+1]), .y_o(c1_y[g+1]),
      .z_o(c1_z[g+1]), .side_o(c1_s[g+1])
    );
  end

  // latitude chain
  logic                 c2_vld [ANGLE_BITS+1];
  logic                 c2_zero[ANGLE_BITS+1];
  logic signed [DW-1:0] c2_x   [ANGLE_BITS+1];
  logic signed [DW-1:0] c2_y   [ANGLE_BITS+1];
  logic signed [ZW-1:0] c2_z   [ANGLE_BITS+1];
  logic [ZW-1:0]        c2_s   [ANGLE_BITS+1];

  logic                 p2_vld_r, p2_zero_r;
  logic signed [DW-1:0] p2_x_r, p2_y_r, p2_x_nxt, p2_y_nxt, raw_x2, raw_y2;
  logic signed [ZW-1:0] p2_z_r, p2_z_nxt, p2_phi_r, phi_nxt;

  always_comb begin
    raw_x2  = c1_x[ANGLE_BITS];
    raw_y2  = $signed(c1_s[ANGLE_BITS]);
    phi_nxt = c1_zero[ANGLE_BITS] ? '0 : c1_z[ANGLE_BITS];
    p2_x_nxt = raw_x2;
    p2_y_nxt = raw_y2;
    p2_z_nxt = '0;
    if (raw_x2 < 0) begin
      if (raw_y2 >= 0) begin
        p2_x_nxt = raw_y2;
        p2_y_nxt = -raw_x2;
        p2_z_nxt = QUARTER;
      end else begin
        p2_x_nxt = -raw_y2;
        p2_y_nxt = raw_x2;
        p2_z_nxt = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= c1_vld[ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_zero_r <= (raw_x2 == '0) && (raw_y2 == '0);
      p2_x_r    <= p2_x_nxt;
      p2_y_r    <= p2_y_nxt;
      p2_z_r    <= p2_z_nxt;
      p2_phi_r  <= phi_nxt;
    end
  end

  assign c2_vld[0]  = p2_vld_r;
  assign c2_zero[0] = p2_zero_r;
  assign c2_x[0]    = p2_x_r;
  assign c2_y[0]    = p2_y_r;
  assign c2_z[0]    = p2_z_r;
  assign c2_s[0]    = p2_phi_r;

  for (genvar g = 0; g < ANGLE_BITS; g++) begin : g_lat
    cmep_cell #(.STAGE(g), .ANGLE_BITS(ANGLE_BITS), .SIDE_W(ZW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(c2_vld[g]), .zero_i(c2_zero[g]), .x_i(c2_x[g]), .y_i(c2_y[g]),
      .z_i(c2_z[g]), .side_i(c2_s[g]),
      .vld_o(c2_vld[g+1]), .zero_o(c2_zero[g+1]), .x_o(c2_x[g+1]), .y_o(c2_y[g+1]),
      .z_o(c2_z[g+1]), .side_o(c2_s[g+1])
    );
  end

  // scale to source coordinates
  logic                 m_vld_r;
  logic signed [HW-1:0] m_hu_r, m_hv_r, hu_nxt, hv_nxt;
  logic signed [ZW-1:0] theta;
  logic signed [ZW:0]   du;
  logic signed [ZW+1:0] dv;

  always_comb begin
    theta  = c2_zero[ANGLE_BITS] ? '0 : c2_z[ANGLE_BITS];
    du     = (ZW+1)'($signed(c2_s[ANGLE_BITS])) + HALF;
    dv     = ((ZW+2)'(QUARTER) - (ZW+2)'(theta)) <<< 1;
    hu_nxt = HW'(du) * HW'($signed({1'b0, width_r}));
    hv_nxt = HW'(dv) * HW'($signed({1'b0, height_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= c2_vld[ANGLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hu_r <= hu_nxt;
      m_hv_r <= hv_nxt;
    end
  end

  // footprint and output register
  logic [13:0] cl_nxt, cr_nxt, rt_nxt, rb_nxt;
  logic [15:0] fs_nxt, ft_nxt;
  logic        o_vld_r;
  logic [13:0] o_cl_r, o_cr_r, o_rt_r, o_rb_r;
  logic [15:0] o_fs_r, o_ft_r;

  cmep_fp #(.ANGLE_BITS(ANGLE_BITS)) u_fp_u (
    .held(m_hu_r), .size(width_r), .lo(cl_nxt), .hi(cr_nxt), .frac(fs_nxt)
  );

  cmep_fp #(.ANGLE_BITS(ANGLE_BITS)) u_fp_v (
    .held(m_hv_r), .size(height_r), .lo(rt_nxt), .hi(rb_nxt), .frac(ft_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cl_r <= cl_nxt;
      o_cr_r <= cr_nxt;
      o_rt_r <= rt_nxt;
      o_rb_r <= rb_nxt;
      o_fs_r <= fs_nxt;
      o_ft_r <= ft_nxt;
    end
  end

  assign out_valid      = o_vld_r;
  assign out_col_left   = o_cl_r;
  assign out_col_right  = o_cr_r;
  assign out_row_top    = o_rt_r;
  assign out_row_bottom = o_rb_r;
  assign out_frac_s     = o_fs_r;
  assign out_frac_t     = o_ft_r;

  `CMEP_IMPLY(a_col_order, out_valid, out_col_right >= out_col_left, "column order")
  `CMEP_IMPLY(a_row_order, out_valid, out_row_bottom >= out_row_top, "row order")
  `CMEP_IMPLY(a_col_step, out_valid, out_col_right - out_col_left <= 14'd1, "column step")
  `CMEP_CHECK(a_stall_hold, !(out_valid && !out_ready && in_ready), "stall leak")

endmodule
